// ----- sv/mandelbrot_escape_test_defines.svh -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_test_defines
// assertion macros used by the escape test iteration core
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TEST_DEFINES_SVH
`define MANDELBROT_ESCAPE_TEST_DEFINES_SVH

`ifndef SYNTHESIS
`define MBET_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MBET_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MBET_ASSERT(lbl, prop, msg)
`define MBET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/mbet_pkg.sv -----
// ----------------------------------------------------------------------------
// mbet_pkg
// shared types, constants and saturation helpers for the escape test
// ----------------------------------------------------------------------------
package mbet_pkg;

    localparam int MAX_ITER_DEF  = 50;
    localparam int FRAC_BITS_DEF = 24;

    localparam int IMG_WIDTH  = 128;
    localparam int IMG_HEIGHT = 64;
    localparam int COL_SHIFT  = $clog2(IMG_WIDTH);
    localparam int ROW_SHIFT  = $clog2(IMG_HEIGHT);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 8;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [IDX_W-1:0] REG_X_OFFSET = 8'd0;
    localparam logic [IDX_W-1:0] REG_Y_OFFSET = 8'd1;
    localparam logic [IDX_W-1:0] REG_X_SPAN   = 8'd2;
    localparam logic [IDX_W-1:0] REG_Y_SPAN   = 8'd3;

    localparam logic signed [WORD_W-1:0] X_OFFSET_RST = 32'sd41943040;
    localparam logic signed [WORD_W-1:0] Y_OFFSET_RST = 32'sd18790482;
    localparam logic signed [WORD_W-1:0] X_SPAN_RST   = 32'sd58720256;
    localparam logic signed [WORD_W-1:0] Y_SPAN_RST   = 32'sd37580964;

    localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] x_offset;
        logic signed [WORD_W-1:0] y_offset;
        logic signed [WORD_W-1:0] x_span;
        logic signed [WORD_W-1:0] y_span;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] c_re;
        logic signed [WORD_W-1:0] c_im;
    } coord_t;

    function automatic logic signed [WORD_W-1:0] sat64(input logic signed [63:0] v);
        logic signed [WORD_W-1:0] r;
        if ((&v[63:31]) || !(|v[63:31]))
            r = v[31:0];
        else if (v[63])
            r = S32_MIN;
        else
            r = S32_MAX;
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat33(input logic signed [32:0] v);
        logic signed [WORD_W-1:0] r;
        if (v[32] == v[31])
            r = v[31:0];
        else if (v[32])
            r = S32_MIN;
        else
            r = S32_MAX;
        return r;
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_add(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) + $signed({b[31], b});
        return sat33(s);
    endfunction

    function automatic logic signed [WORD_W-1:0] sat_sub(input logic signed [WORD_W-1:0] a,
                                                        input logic signed [WORD_W-1:0] b);
        logic signed [32:0] s;
        s = $signed({a[31], a}) - $signed({b[31], b});
        return sat33(s);
    endfunction

endpackage

// ----- sv/mbet_front.sv -----
// ----------------------------------------------------------------------------
// mbet_front
// accepts pixel words, scales them by the span and subtracts the offset
// ----------------------------------------------------------------------------
module mbet_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [6:0]            pixel_col,
    input  logic [5:0]            pixel_row,
    input  mbet_pkg::cfg_t        cfg,
    output logic                  q_push,
    output mbet_pkg::coord_t      q_wdata,
    input  logic                  q_full
);
    import mbet_pkg::*;

    logic signed [39:0]       prod_re;
    logic signed [39:0]       prod_im;
    logic signed [63:0]       prod_re64;
    logic signed [63:0]       prod_im64;
    logic                     fv_reg;
    logic signed [WORD_W-1:0] scaled_re_reg;
    logic signed [WORD_W-1:0] scaled_im_reg;
    logic signed [WORD_W-1:0] scaled_re_next;
    logic signed [WORD_W-1:0] scaled_im_next;
    logic                     take;

    assign prod_re   = $signed({1'b0, pixel_col}) * cfg.x_span;
    assign prod_im   = $signed({1'b0, pixel_row}) * cfg.y_span;
    assign prod_re64 = {{24{prod_re[39]}}, prod_re};
    assign prod_im64 = {{24{prod_im[39]}}, prod_im};

    assign scaled_re_next = sat64(prod_re64 >>> COL_SHIFT);
    assign scaled_im_next = sat64(prod_im64 >>> ROW_SHIFT);

    assign q_push   = fv_reg && !q_full;
    assign in_ready = !fv_reg || q_push;
    assign take     = in_valid && in_ready;

    assign q_wdata.c_re = sat_sub(scaled_re_reg, cfg.x_offset);
    assign q_wdata.c_im = sat_sub(scaled_im_reg, cfg.y_offset);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else if (take)
            fv_reg <= 1'b1;
        else if (q_push)
            fv_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            scaled_re_reg <= scaled_re_next;
            scaled_im_reg <= scaled_im_next;
        end
    end

endmodule

// ----- sv/mbet_queue.sv -----
// ----------------------------------------------------------------------------
// mbet_queue
// short queue of mapped points between the front and the iteration core
// ----------------------------------------------------------------------------
module mbet_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  mbet_pkg::coord_t      wdata,
    output logic                  full,
    input  logic                  pop,
    output mbet_pkg::coord_t      rdata,
    output logic                  not_empty
);
    import mbet_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    coord_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full      = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign rdata     = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

endmodule

// ----- sv/mbet_core.sv -----
// ----------------------------------------------------------------------------
// mbet_core
// runs z = z^2 + c on one point and holds the in-set word for output
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_test_defines.svh"

module mbet_core #(
    parameter int MAX_ITER  = mbet_pkg::MAX_ITER_DEF,
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_not_empty,
    input  mbet_pkg::coord_t      q_rdata,
    output logic                  q_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  in_set
);
    import mbet_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITER + 1);
    localparam logic [33:0] LIMIT = 34'(4) << FRAC_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     res_reg;
    logic                     res_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     in_set_reg;
    logic                     in_set_next;

    logic signed [WORD_W-1:0] c_re_reg;
    logic signed [WORD_W-1:0] c_im_reg;
    logic signed [WORD_W-1:0] zr_reg;
    logic signed [WORD_W-1:0] zi_reg;
    logic signed [WORD_W-1:0] zr2_reg;
    logic signed [WORD_W-1:0] zi2_reg;
    logic signed [WORD_W-1:0] zri_reg;
    logic signed [WORD_W-1:0] zr_next;
    logic signed [WORD_W-1:0] zi_next;
    logic signed [WORD_W-1:0] zr2_next;
    logic signed [WORD_W-1:0] zi2_next;
    logic signed [WORD_W-1:0] zri_next;

    logic signed [63:0]       p_rr;
    logic signed [63:0]       p_ii;
    logic signed [63:0]       p_ri;
    logic [33:0]              mag;
    logic                     keep_going;

    assign p_rr = zr_reg * zr_reg;
    assign p_ii = zi_reg * zi_reg;
    assign p_ri = zr_reg * zi_reg;

    assign mag        = {2'b00, zr2_reg} + {2'b00, zi2_reg};
    assign keep_going = (mag <= LIMIT) && (count_reg < CNT_W'(MAX_ITER));

    assign q_pop     = (state_reg == S_IDLE) && q_not_empty;
    assign out_valid = out_valid_reg;
    assign in_set    = in_set_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        in_set_next    = in_set_reg;
        zr_next        = zr_reg;
        zi_next        = zi_reg;
        zr2_next       = zr2_reg;
        zi2_next       = zi2_reg;
        zri_next       = zri_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    count_next = '0;
                    zr_next    = '0;
                    zi_next    = '0;
                    zr2_next   = '0;
                    zi2_next   = '0;
                    zri_next   = '0;
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (keep_going)
                begin
                    zi_next    = sat_add(zri_reg, c_im_reg);
                    zr_next    = sat_add(sat_sub(zr2_reg, zi2_reg), c_re_reg);
                    count_next = count_reg + 1'b1;
                    state_next = S_MUL;
                end
                else
                begin
                    res_next   = (count_reg == CNT_W'(MAX_ITER));
                    state_next = S_DONE;
                end
            end
            S_MUL:
            begin
                zr2_next   = sat64(p_rr >>> FRAC_BITS);
                zi2_next   = sat64(p_ii >>> FRAC_BITS);
                zri_next   = sat64(p_ri >>> (FRAC_BITS - 1));
                state_next = S_ADD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    in_set_next    = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            c_re_reg <= q_rdata.c_re;
            c_im_reg <= q_rdata.c_im;
        end
        res_reg    <= res_next;
        in_set_reg <= in_set_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        zr2_reg    <= zr2_next;
        zi2_reg    <= zi2_next;
        zri_reg    <= zri_next;
    end

    `MBET_ASSERT(a_count_range, count_reg <= CNT_W'(MAX_ITER), "iteration count past limit")
    `MBET_ASSERT_NEXT(a_mul_then_add, state_reg == S_MUL, state_reg == S_ADD, "mul not followed by add")
    `MBET_ASSERT_NEXT(a_limit_stops, (state_reg == S_ADD) && (count_reg == CNT_W'(MAX_ITER)), state_reg == S_DONE && res_reg, "limit reached but not reported in set")
    `MBET_ASSERT(a_word_from_done, $rose(out_valid_reg) |-> $past(state_reg) == S_DONE, "result word without finished item")

endmodule

// ----- sv/mandelbrot_escape_test.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_test
// maps a pixel to a complex point and tests it for escape under z^2 + c
// ----------------------------------------------------------------------------
//   channel | signals                              | word
//   in      | in_valid, in_ready                   | pixel_col, pixel_row
//   out     | out_valid, out_ready                 | in_set
//   cfg     | cfg_valid, cfg_ready (always high)   | cfg_index, cfg_data
//
//   out_valid rises after the input handshake once the point has passed the front
//   register, the queue and the core's loop; the iteration loop is an add state and
//   a multiply state that take turns on a single set of three 32x32 multipliers
//   the front and a two-entry queue keep taking words while the loop runs
//   a held result word stalls the loop in its final state until out_ready
//   reset is asynchronous active low, no clearing pass is needed
// ----------------------------------------------------------------------------
module mandelbrot_escape_test #(
    parameter int MAX_ITER  = mbet_pkg::MAX_ITER_DEF,
    parameter int FRAC_BITS = mbet_pkg::FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [6:0]  pixel_col,
    input  logic [5:0]  pixel_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        in_set,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import mbet_pkg::*;

    cfg_t   cfg_reg;
    coord_t q_wdata;
    coord_t q_rdata;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_not_empty;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_offset <= X_OFFSET_RST;
            cfg_reg.y_offset <= Y_OFFSET_RST;
            cfg_reg.x_span   <= X_SPAN_RST;
            cfg_reg.y_span   <= Y_SPAN_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_X_OFFSET: cfg_reg.x_offset <= cfg_data;
                REG_Y_OFFSET: cfg_reg.y_offset <= cfg_data;
                REG_X_SPAN:   cfg_reg.x_span   <= cfg_data;
                REG_Y_SPAN:   cfg_reg.y_span   <= cfg_data;
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    mbet_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .cfg       (cfg_reg),
        .q_push    (q_push),
        .q_wdata   (q_wdata),
        .q_full    (q_full)
    );

    mbet_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty)
    );

    mbet_core #(
        .MAX_ITER  (MAX_ITER),
        .FRAC_BITS (FRAC_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .in_set      (in_set)
    );

endmodule

// ----- tb/mandelbrot_escape_test_tb.sv -----
// ----------------------------------------------------------------------------
// mandelbrot_escape_test_tb
// self-checking bench: pixels go in under several views of the plane, and
// each in_set word is checked against a fixed-point orbit predictor
// ----------------------------------------------------------------------------
module mandelbrot_escape_test_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbet_pkg::*;

    localparam int ITER_LIMIT = MAX_ITER_DEF;
    localparam int Q_FRAC = FRAC_BITS_DEF;
    localparam longint ESCAPE_BOUND = longint'(4) << Q_FRAC;
    localparam longint WORD_HI = 2147483647;
    localparam longint WORD_LO = -longint'(2147483647) - 1;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 8'd4;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 8'hff;
    localparam int GAP_MAX = 19;
    localparam int DRAIN_CYCLES = 2 * MAX_ITER_DEF + 10;

    typedef struct {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } pixel_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [COL_W-1:0]  pixel_col = '0;
    logic [ROW_W-1:0]  pixel_row = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              in_set;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IDX_W-1:0]  cfg_index = '0;
    logic [WORD_W-1:0] cfg_data = '0;

    longint view_x_offset = X_OFFSET_RST;
    longint view_y_offset = Y_OFFSET_RST;
    longint view_x_span = X_SPAN_RST;
    longint view_y_span = Y_SPAN_RST;

    pixel_t pixel_queue[$];
    bit membership_queue[$];
    int unsigned pixels_sent = 0;
    int unsigned pixels_checked = 0;
    int unsigned failures = 0;
    int in_gap_max = 0;
    int out_gap_max = 0;
    int in_wait = 0;
    int out_wait = 0;

    mandelbrot_escape_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel_col (pixel_col),
        .pixel_row (pixel_row),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .in_set    (in_set),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clamp_word(input longint v);
        if (v > WORD_HI)
            return WORD_HI;
        if (v < WORD_LO)
            return WORD_LO;
        return v;
    endfunction

    function automatic void run_orbit(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                                      output int steps, output bit late_escape);
        longint c_re, c_im, re, im, re_sq, im_sq;
        c_re = clamp_word(clamp_word((longint'(col) * view_x_span) >>> COL_SHIFT)
                          - view_x_offset);
        c_im = clamp_word(clamp_word((longint'(row) * view_y_span) >>> ROW_SHIFT)
                          - view_y_offset);
        re = 0;
        im = 0;
        re_sq = 0;
        im_sq = 0;
        steps = 0;
        while (re_sq + im_sq <= ESCAPE_BOUND && steps < ITER_LIMIT)
        begin
            im = clamp_word(clamp_word((re * im) >>> (Q_FRAC - 1)) + c_im);
            re = clamp_word(clamp_word(re_sq - im_sq) + c_re);
            re_sq = clamp_word((re * re) >>> Q_FRAC);
            im_sq = clamp_word((im * im) >>> Q_FRAC);
            steps++;
        end
        late_escape = (steps >= ITER_LIMIT) && (re_sq + im_sq > ESCAPE_BOUND);
    endfunction

    function automatic bit predict_in_set(input logic [COL_W-1:0] col,
                                          input logic [ROW_W-1:0] row);
        int steps;
        bit late_escape;
        run_orbit(col, row, steps, late_escape);
        return steps >= ITER_LIMIT;
    endfunction

    // input side
    always @(posedge clk or negedge rst_n)
    begin : pixel_driver
        pixel_t next_pixel;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                membership_queue.push_back(predict_in_set(pixel_col, pixel_row));
            if (!in_valid || in_ready)
            begin
                if (in_wait > 0)
                begin
                    in_valid <= 1'b0;
                    in_wait <= in_wait - 1;
                end
                else if (pixel_queue.size() > 0)
                begin
                    next_pixel = pixel_queue.pop_front();
                    in_valid <= 1'b1;
                    pixel_col <= next_pixel.col;
                    pixel_row <= next_pixel.row;
                    in_wait <= $urandom_range(0, in_gap_max);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        bit want;
        int stall;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_wait <= 0;
        end
        else if (out_valid && out_ready)
        begin
            if (membership_queue.size() == 0)
            begin
                $display("%0t ns: unexpected in_set word, expected none, actual %0b",
                         $time, in_set);
                failures++;
            end
            else
            begin
                want = membership_queue.pop_front();
                pixels_checked++;
                if (in_set !== want)
                begin
                    $display("%0t ns: in_set mismatch, expected %0b, actual %0b",
                             $time, want, in_set);
                    failures++;
                end
            end
            stall = $urandom_range(0, out_gap_max);
            out_ready <= (stall == 0);
            out_wait <= stall;
        end
        else if (out_wait > 0)
        begin
            out_ready <= (out_wait == 1);
            out_wait <= out_wait - 1;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic write_register(input logic [IDX_W-1:0] index, input logic [WORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        case (index)
            REG_X_OFFSET: view_x_offset = longint'($signed(value));
            REG_Y_OFFSET: view_y_offset = longint'($signed(value));
            REG_X_SPAN:   view_x_span = longint'($signed(value));
            REG_Y_SPAN:   view_y_span = longint'($signed(value));
            default: ;
        endcase
    endtask

    task automatic set_view(input longint x_off, input longint y_off,
                            input longint x_sp, input longint y_sp);
        write_register($urandom_range(0, 1) ? REG_SPARE_HI : IDX_W'($urandom_range(4, 254)),
                       $urandom);
        write_register(REG_X_OFFSET, WORD_W'(x_off));
        write_register(REG_Y_OFFSET, WORD_W'(y_off));
        write_register(REG_X_SPAN, WORD_W'(x_sp));
        write_register(REG_Y_SPAN, WORD_W'(y_sp));
        write_register(REG_SPARE_LO, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // view centered on a random point around the set, random size and orientation
    task automatic set_random_view();
        longint span_re, span_im, mid_re, mid_im;
        span_re = $urandom_range(1 << 18, 1 << 26);
        span_im = $urandom_range(1 << 18, 1 << 26);
        if ($urandom_range(0, 3) == 0)
            span_re = -span_re;
        if ($urandom_range(0, 3) == 0)
            span_im = -span_im;
        mid_re = longint'($urandom_range(0, 41943040)) - 33554432;
        mid_im = longint'($urandom_range(0, 40265318)) - 20132659;
        set_view(span_re / 2 - mid_re, span_im / 2 - mid_im, span_re, span_im);
    endtask

    task automatic queue_pixel(input int col, input int row);
        pixel_t p;
        p.col = COL_W'(col);
        p.row = ROW_W'(row);
        pixel_queue.push_back(p);
        pixels_sent++;
    endtask

    task automatic queue_corners();
        queue_pixel(0, 0);
        queue_pixel(IMG_WIDTH - 1, 0);
        queue_pixel(0, IMG_HEIGHT - 1);
        queue_pixel(IMG_WIDTH - 1, IMG_HEIGHT - 1);
    endtask

    task automatic queue_random_pixels(input int count);
        repeat (count)
            queue_pixel($urandom_range(0, IMG_WIDTH - 1), $urandom_range(0, IMG_HEIGHT - 1));
    endtask

    // pixels whose final iteration pushes the orbit out of the disk
    task automatic queue_late_escapes(input int most);
        int steps;
        bit late_escape;
        int found;
        found = 0;
        for (int r = 0; r < IMG_HEIGHT && found < most; r++)
            for (int c = 0; c < IMG_WIDTH && found < most; c++)
            begin
                run_orbit(COL_W'(c), ROW_W'(r), steps, late_escape);
                if (late_escape)
                begin
                    queue_pixel(c, r);
                    found++;
                end
            end
    endtask

    task automatic drain();
        do @(posedge clk); while (pixels_checked != pixels_sent);
    endtask

    task automatic set_idling(input int in_max, input int out_max);
        in_gap_max = in_max;
        out_gap_max = out_max;
    endtask

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset view: edges, bit patterns, a point inside the main body
        set_idling(0, 0);
        queue_corners();
        queue_pixel(64, 32);
        queue_pixel(71, 32);
        queue_pixel(85, 42);
        queue_pixel(42, 21);
        queue_pixel(1, 1);
        queue_pixel(126, 62);
        queue_late_escapes(2);
        drain();

        set_idling(GAP_MAX, GAP_MAX);
        queue_random_pixels(400);
        drain();

        // zoom on the valley between the main body and the bulb
        set_view(2097152 + 12582912, 2097152 - 1677722, 4194304, 4194304);
        set_idling(0, 0);
        queue_late_escapes(2);
        queue_random_pixels(300);
        drain();

        // extreme registers, sums saturate
        set_view(WORD_LO, WORD_HI, WORD_HI, WORD_LO);
        set_idling(GAP_MAX, 0);
        queue_corners();
        queue_random_pixels(30);
        drain();
        set_view(WORD_HI, WORD_LO, WORD_LO, WORD_HI);
        set_idling(0, GAP_MAX);
        queue_corners();
        queue_random_pixels(30);
        drain();
        set_view(0, 0, 0, 0);
        queue_corners();
        queue_random_pixels(30);
        drain();
        set_view(WORD_HI, WORD_HI, WORD_HI, WORD_HI);
        set_idling(GAP_MAX, GAP_MAX);
        queue_corners();
        queue_random_pixels(30);
        drain();

        repeat (6)
        begin
            set_random_view();
            set_idling($urandom_range(0, 1) ? GAP_MAX : 0, $urandom_range(0, 1) ? GAP_MAX : 0);
            queue_random_pixels(120);
            drain();
        end

        set_view(X_OFFSET_RST, Y_OFFSET_RST, X_SPAN_RST, Y_SPAN_RST);
        set_idling(GAP_MAX, GAP_MAX);
        queue_random_pixels(180);
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && membership_queue.size() == 0)
            $display("mandelbrot_escape_test verification clean");
        else
            $display("mandelbrot_escape_test verification failed");
        $finish;
    end

    initial
    begin : watchdog
        #8000000;
        $display("mandelbrot_escape_test verification failed");
        $finish;
    end

endmodule
